// File: src/atm_pkg.sv
// ============================================================================
// atm_pkg: shared types and constants for the alarm table matcher
// Holds the table size, command codes, time constants and the command and
// status records that pass between the controller and the datapath.
// ============================================================================
package atm_pkg;

    // Number of alarm slots in the table.
    localparam int TABLE_DEPTH = 8;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PTR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Time-of-day arithmetic.
    localparam int             POS_W       = 11;
    localparam logic [POS_W-1:0] DAY_MIN   = 11'd1440;
    localparam logic [5:0]     HOUR_MIN    = 6'd60;
    localparam logic [5:0]     LAST_NONE   = 6'd60;
    // floor(x / 60) == (x * 1093) >> 16 for every x in 0..1440.
    localparam int             HOUR_RECIP  = 1093;
    localparam int             RECIP_SHIFT = 16;

    // Stream widths.
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 24;

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_TOGGLE = 3'd2,
        MODE_EDIT   = 3'd3,
        MODE_CHECK  = 3'd4,
        MODE_QUERY  = 3'd5
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted input transfer
        logic apply;   // execute table updates, latch status
        logic read;    // fetch the slot under the scan pointer
        logic eval;    // compare the fetched slot, advance the pointer
        logic div;     // split the best distance into hours
        logic emit;    // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;
        logic  check_go;    // new minute and nothing ringing
        logic  count_zero;
        logic  last_entry;  // scan pointer is on the last used slot
        logic  out_free;    // output register can take a result
    } t_dp_stat;

endpackage

// File: src/atm_ctrl.sv
// ============================================================================
// atm_ctrl: command sequencer of the alarm table matcher
// One-hot state machine that steps the datapath through update, scan,
// division and output phases for one command at a time.
// ============================================================================
module atm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  atm_pkg::t_dp_stat i_stat,
    output atm_pkg::t_dp_cmd  o_cmd
);
    import atm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_APPLY = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                if (!i_stat.count_zero &&
                    ((i_stat.mode == MODE_CHECK && i_stat.check_go) ||
                     i_stat.mode == MODE_QUERY)) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.last_entry) begin
                    n_state = (i_stat.mode == MODE_QUERY) ? S_DIV : S_EMIT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

endmodule

// File: src/atm_datapath.sv
// ============================================================================
// atm_datapath: alarm table, scan evaluation and output register
// Holds the packed alarm table, the captured command, the running best
// distance and the result register that faces the output stream.
// ============================================================================
module atm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  atm_pkg::t_dp_cmd              i_cmd,
    output atm_pkg::t_dp_stat             o_stat,
    input  logic [atm_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    input  logic [atm_pkg::S_USER_W-1:0]  i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [atm_pkg::M_DATA_W-1:0]  o_m_axis_tdata
);
    import atm_pkg::*;

    // Alarm table.
    logic [4:0]             r_hour [TABLE_DEPTH];
    logic [5:0]             r_min  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_act;
    logic [CNT_W-1:0]       r_count;
    logic [5:0]             r_last;
    logic                   r_out_valid;

    // Captured command.
    t_mode            r_cmd_mode;
    logic [2:0]       r_cmd_idx;
    logic [4:0]       r_cmd_ah;
    logic [5:0]       r_cmd_am;
    logic [4:0]       r_cmd_nh;
    logic [5:0]       r_cmd_nm;
    logic             r_cmd_ring;
    logic [PTR_W-1:0] r_ptr;

    // Working results.
    logic             r_status, r_tog, r_start, r_found;
    logic [POS_W-1:0] r_now_pos, r_ent_pos, r_best;
    logic             r_ent_act, r_ent_hit;
    logic [4:0]       r_q;
    logic [M_DATA_W-1:0] r_out_data;

    logic             idx_bad, full, reject;
    logic [11:0]      diff_w;
    logic [POS_W-1:0] diff;
    logic [21:0]      prod;
    logic [POS_W-1:0] q60;
    logic [5:0]       rem;

    function automatic logic [POS_W-1:0] day_pos(input logic [4:0] h, input logic [5:0] m);
        logic [POS_W-1:0] t;
        t = {h, 6'b0} - {4'b0, h, 2'b0} + {5'b0, m};
        if (t >= DAY_MIN) begin
            t = t - DAY_MIN;
        end
        return t;
    endfunction

    assign idx_bad = (32'(r_cmd_idx) >= 32'(r_count));
    assign full    = (r_count >= CNT_W'(TABLE_DEPTH));

    always_comb begin
        unique case (r_cmd_mode)
            MODE_ADD:    reject = full;
            MODE_DELETE: reject = idx_bad;
            MODE_TOGGLE: reject = idx_bad;
            MODE_EDIT:   reject = idx_bad;
            default:     reject = 1'b0;
        endcase
    end

    // Forward distance; an alarm at the current time is a full day away.
    always_comb begin
        if (r_ent_pos > r_now_pos) begin
            diff_w = {1'b0, r_ent_pos} - {1'b0, r_now_pos};
        end else begin
            diff_w = {1'b0, r_ent_pos} + {1'b0, DAY_MIN} - {1'b0, r_now_pos};
        end
        diff = diff_w[POS_W-1:0];
    end

    assign prod = {11'b0, r_best} * 22'(HOUR_RECIP);
    assign q60  = {r_q, 6'b0} - {4'b0, r_q, 2'b0};
    assign rem  = 6'(r_best - q60);

    // Table and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_hour[i] <= '0;
                r_min[i]  <= '0;
            end
            r_act       <= '0;
            r_count     <= '0;
            r_last      <= LAST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.apply) begin
                unique case (r_cmd_mode)
                    MODE_ADD: begin
                        if (!full) begin
                            r_hour[PTR_W'(r_count)] <= r_cmd_ah;
                            r_min[PTR_W'(r_count)]  <= r_cmd_am;
                            r_act[PTR_W'(r_count)]  <= 1'b1;
                            r_count                 <= r_count + CNT_W'(1);
                        end
                    end
                    MODE_DELETE: begin
                        // Slots past the count are always zero, so shifting
                        // zero into the top also clears the freed slot.
                        if (!idx_bad) begin
                            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                                if (i >= int'(r_ptr)) begin
                                    r_hour[i] <= r_hour[i+1];
                                    r_min[i]  <= r_min[i+1];
                                    r_act[i]  <= r_act[i+1];
                                end
                            end
                            r_hour[TABLE_DEPTH-1] <= '0;
                            r_min[TABLE_DEPTH-1]  <= '0;
                            r_act[TABLE_DEPTH-1]  <= 1'b0;
                            r_count               <= r_count - CNT_W'(1);
                        end
                    end
                    MODE_TOGGLE: begin
                        if (!idx_bad) begin
                            r_act[r_ptr] <= ~r_act[r_ptr];
                        end
                    end
                    MODE_EDIT: begin
                        if (!idx_bad) begin
                            r_hour[r_ptr] <= r_cmd_ah;
                            r_min[r_ptr]  <= r_cmd_am;
                            r_act[r_ptr]  <= 1'b1;
                        end
                    end
                    MODE_CHECK: begin
                        if (r_cmd_nm != r_last) begin
                            r_last <= r_cmd_nm;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Command capture, scan and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_mode <= t_mode'(i_s_axis_tuser);
            r_cmd_idx  <= i_s_axis_tdata[2:0];
            r_cmd_ah   <= i_s_axis_tdata[7:3];
            r_cmd_am   <= i_s_axis_tdata[13:8];
            r_cmd_nh   <= i_s_axis_tdata[18:14];
            r_cmd_nm   <= i_s_axis_tdata[24:19];
            r_cmd_ring <= i_s_axis_tdata[25];
            r_ptr      <= PTR_W'(i_s_axis_tdata[2:0]);
            r_status   <= 1'b0;
            r_tog      <= 1'b0;
            r_start    <= 1'b0;
            r_found    <= 1'b0;
            r_best     <= '0;
            r_q        <= '0;
        end
        if (i_cmd.apply) begin
            r_status  <= reject;
            r_tog     <= (r_cmd_mode == MODE_TOGGLE) && !idx_bad && !r_act[r_ptr];
            r_now_pos <= day_pos(r_cmd_nh, r_cmd_nm);
            if (r_cmd_mode == MODE_CHECK || r_cmd_mode == MODE_QUERY) begin
                r_ptr <= '0;
            end
        end
        if (i_cmd.read) begin
            r_ent_pos <= day_pos(r_hour[r_ptr], r_min[r_ptr]);
            r_ent_act <= r_act[r_ptr];
            r_ent_hit <= r_act[r_ptr] && (r_hour[r_ptr] == r_cmd_nh) &&
                         (r_min[r_ptr] == r_cmd_nm);
        end
        if (i_cmd.eval) begin
            r_ptr <= r_ptr + PTR_W'(1);
            if (r_cmd_mode == MODE_CHECK && r_ent_hit) begin
                r_start <= 1'b1;
            end
            if (r_cmd_mode == MODE_QUERY && r_ent_act && (!r_found || diff < r_best)) begin
                r_best  <= diff;
                r_found <= 1'b1;
            end
        end
        if (i_cmd.div) begin
            r_q <= 5'(prod >> RECIP_SHIFT);
        end
        if (i_cmd.emit) begin
            r_out_data <= {5'b0, 4'(r_count), rem, r_q, r_found, r_start, r_tog, r_status};
        end
    end

    assign o_stat.mode       = r_cmd_mode;
    assign o_stat.check_go   = (r_cmd_nm != r_last) && !r_cmd_ring;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.last_entry = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_count);
    assign o_stat.out_free   = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: src/alarm_table_matcher.sv
// ============================================================================
// alarm_table_matcher: packed alarm table with match and next-alarm search
// Stores up to TABLE_DEPTH alarms and answers add, delete, toggle, edit,
// once-per-minute match check and time-to-next-alarm commands.
// ============================================================================
//
// Channel   Direction  Carries
// s_axis    in         one command per transfer (mode in tuser)
// m_axis    out        exactly one result per command
//
// Timing: table updates, rejected commands and skipped checks pass through
// the apply and emit states between one acceptance and the next, and the
// result is registered out of the emit state. A check that runs scans the
// used slots with one fetch and one compare per slot; a query adds an hour
// split after the scan. The slot scan sets the time that a command takes.
// Reset clears the whole table at once; no clearing pass follows.
// Stalls: a result waits in the output register while the next command is
// accepted; only a second result stalls until the first transfer completes.
//
module alarm_table_matcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Fields from bit 0 up: alarm_index[2:0], alarm_hours[7:3],
    // alarm_minutes[13:8], now_hours[18:14], now_minutes[24:19],
    // ringing_now[25], zero fill[31:26].
    input  logic [atm_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0 up: mode[2:0].
    input  logic [atm_pkg::S_USER_W-1:0]  i_s_axis_tuser,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // Fields from bit 0 up: status[0], toggled_active[1], start_ringing[2],
    // next_found[3], remaining_hours[8:4], remaining_minutes[14:9],
    // alarm_count[18:15], zero fill[23:19].
    output logic [atm_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready
);
    import atm_pkg::*;

    // The controller only sequences; all table state and arithmetic sit in
    // the datapath, so the two halves talk through these two records.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    atm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (dp_stat),
        .o_cmd           (dp_cmd)
    );

    atm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// File: src/atm_checker.sv
// ============================================================================
// atm_checker: port-level checks for the alarm table matcher
// Watches the stream ports and flags results or handshakes that cannot
// come from a correct table matcher.
// ============================================================================
module atm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic [atm_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    input logic [atm_pkg::S_USER_W-1:0]  i_s_axis_tuser,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [atm_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready
);
    import atm_pkg::*;

    // Leftover minutes always come from a remainder by sixty.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:9] < HOUR_MIN))
        else $error("remaining minutes out of range");

    // The reported count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[18:15]) <= TABLE_DEPTH))
        else $error("alarm count exceeds table depth");

    // Without a found alarm the remaining time fields are zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[3]) |-> (o_m_axis_tdata[14:4] == '0))
        else $error("remaining time set without a found alarm");

    // One command at a time: acceptance closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind alarm_table_matcher atm_checker u_atm_checker (.*);
